// ===== hdl/aidec_pkg.sv =====
`default_nettype none
package aidec_pkg;

    // opcodes carried in the input tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BOARD_TYPE = 2'd0;
    localparam logic [1:0] CFG_DIP_BANK0  = 2'd1;
    localparam logic [1:0] CFG_DIP_BANK1  = 2'd2;
    localparam logic [1:0] CFG_DIP_BANK2  = 2'd3;

    // scroll ram geometry
    localparam int RAM_DEPTH = 64;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // bus map
    localparam logic [15:0] ADDR_RAM_BASE    = 16'hE000;
    localparam logic [15:0] ADDR_SPRITE_BANK = 16'hE043;
    localparam logic [15:0] ADDR_INT_ENABLE  = 16'hE044;
    localparam logic [15:0] ADDR_ROM_BANK    = 16'hF000;
    localparam logic [15:0] ADDR_DIP1        = 16'hF200;
    localparam logic [15:0] ADDR_SOUND_DIP2  = 16'hF400;
    localparam logic [15:0] ADDR_DIP0        = 16'hF600;
    localparam logic [15:0] ADDR_JOY2        = 16'hF601;
    localparam logic [15:0] ADDR_JOY1        = 16'hF602;
    localparam logic [15:0] ADDR_JOY3        = 16'hF603;

    // scroll bytes mirrored for the scroll_value output
    localparam logic [RAM_AW-1:0] SCROLL_LO_IDX = RAM_AW'(6'h06);
    localparam logic [RAM_AW-1:0] SCROLL_HI_IDX = RAM_AW'(6'h26);

    localparam logic [1:0] BOARD_BANKED   = 2'd2;
    localparam logic [7:0] IRQ_MASK_ALT   = 8'h02;
    localparam logic [7:0] IRQ_MASK_STD   = 8'h04;
    localparam logic [4:0] SLICE_LAST_16  = 5'd15;
    localparam logic [4:0] SLICE_LAST_32  = 5'd31;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [7:0]  joy_port1;
        logic [7:0]  joy_port2;
        logic [7:0]  joy_port3;
    } aidec_item_t;

    typedef struct packed {
        logic        ram_we;
        logic        ram_re;
        logic [7:0]  rd_fixed;
        logic [7:0]  sprite_bank;
        logic        nmi_on;
        logic        irq_on;
        logic [2:0]  rom_bank;
        logic        sound_strobe;
        logic [7:0]  sound_byte;
        logic        irq_pulse;
        logic        nmi_pulse;
        logic [15:0] scroll_value;
    } aidec_res_t;

endpackage
`default_nettype wire

// ===== hdl/aidec_ram.sv =====
`default_nettype none
module aidec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/aidec_ctrl.sv =====
`default_nettype none
module aidec_ctrl
    import aidec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire aidec_item_t item,
    input  wire logic        accept,
    output aidec_res_t       res
);

    logic [1:0] board_reg;
    logic [7:0] dip0_reg;
    logic [7:0] dip1_reg;
    logic [7:0] dip2_reg;
    logic [7:0] sprite_reg;
    logic       nmi_reg;
    logic       irq_reg;
    logic [2:0] bank_reg;
    logic [4:0] slice_reg;
    logic [7:0] scroll_lo_reg;
    logic [7:0] scroll_hi_reg;

    logic [4:0] slice_next;
    logic [4:0] slice_last;
    logic       in_ram;
    logic [RAM_AW-1:0] ram_idx;
    logic [7:0] irq_mask;
    logic [7:0] scroll_lo_next;
    logic [7:0] scroll_hi_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg <= '0;
            dip0_reg  <= '0;
            dip1_reg  <= '0;
            dip2_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOARD_TYPE: board_reg <= cfg_data[1:0];
                CFG_DIP_BANK0:  dip0_reg  <= cfg_data;
                CFG_DIP_BANK1:  dip1_reg  <= cfg_data;
                CFG_DIP_BANK2:  dip2_reg  <= cfg_data;
                default:        board_reg <= board_reg;
            endcase
        end
    end

    assign in_ram   = (item.bus_address[15:RAM_AW] == ADDR_RAM_BASE[15:RAM_AW]);
    assign ram_idx  = item.bus_address[RAM_AW-1:0];
    assign irq_mask = board_reg[1] ? IRQ_MASK_ALT : IRQ_MASK_STD;
    assign slice_last = (board_reg != 2'd0) ? SLICE_LAST_16 : SLICE_LAST_32;

    always_comb
    begin
        res            = '0;
        res.sprite_bank = sprite_reg;
        res.nmi_on     = nmi_reg;
        res.irq_on     = irq_reg;
        res.rom_bank   = bank_reg;
        slice_next     = slice_reg;
        scroll_lo_next = scroll_lo_reg;
        scroll_hi_next = scroll_hi_reg;
        unique case (item.opcode)
            OP_WRITE:
            begin
                if (in_ram)
                begin
                    res.ram_we = 1'b1;
                    if (ram_idx == SCROLL_LO_IDX)
                    begin
                        scroll_lo_next = item.write_data;
                    end
                    if (ram_idx == SCROLL_HI_IDX)
                    begin
                        scroll_hi_next = item.write_data;
                    end
                end
                else if (item.bus_address == ADDR_SPRITE_BANK)
                begin
                    res.sprite_bank = item.write_data;
                end
                else if (item.bus_address == ADDR_INT_ENABLE)
                begin
                    res.nmi_on = item.write_data[0];
                    res.irq_on = |(item.write_data & irq_mask);
                end
                else if (item.bus_address == ADDR_ROM_BANK)
                begin
                    if (board_reg == BOARD_BANKED)
                    begin
                        res.rom_bank = item.write_data[7:5];
                    end
                end
                else if (item.bus_address == ADDR_SOUND_DIP2)
                begin
                    res.sound_strobe = 1'b1;
                    res.sound_byte   = item.write_data;
                end
            end
            OP_READ:
            begin
                unique case (item.bus_address)
                    ADDR_DIP1:       res.rd_fixed = dip1_reg;
                    ADDR_SOUND_DIP2: res.rd_fixed = dip2_reg;
                    ADDR_DIP0:       res.rd_fixed = dip0_reg;
                    ADDR_JOY2:       res.rd_fixed = ~item.joy_port2;
                    ADDR_JOY1:       res.rd_fixed = ~item.joy_port1;
                    ADDR_JOY3:       res.rd_fixed = ~item.joy_port3;
                    default:         res.ram_re   = in_ram;
                endcase
            end
            OP_TICK:
            begin
                res.irq_pulse = irq_reg && (slice_reg == slice_last);
                res.nmi_pulse = nmi_reg && slice_reg[0];
                // a board change can leave the count past the frame end
                slice_next = (slice_reg >= slice_last) ? 5'd0 : slice_reg + 5'd1;
            end
            default:
            begin
                slice_next = slice_reg;
            end
        endcase
        res.scroll_value = {scroll_hi_next, scroll_lo_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_reg    <= '0;
            nmi_reg       <= 1'b0;
            irq_reg       <= 1'b0;
            bank_reg      <= '0;
            slice_reg     <= '0;
            scroll_lo_reg <= '0;
            scroll_hi_reg <= '0;
        end
        else if (accept)
        begin
            sprite_reg    <= res.sprite_bank;
            nmi_reg       <= res.nmi_on;
            irq_reg       <= res.irq_on;
            bank_reg      <= res.rom_bank;
            slice_reg     <= slice_next;
            scroll_lo_reg <= scroll_lo_next;
            scroll_hi_reg <= scroll_hi_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/arcade_io_and_interrupt_decoder_top.sv =====
// latency: a result is valid in the cycle after its input transfer
// throughput: one item per cycle while m_tready is high; a waiting result holds s_tready low
// the scroll ram read goes through the ram's registered read port
// reset clears all control registers and the scroll ram valid bits at once;
// no clearing pass is run, an unwritten ram entry reads as zero
`default_nettype none
module arcade_io_and_interrupt_decoder_top
    import aidec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // bus_address, write_data, joy_port1, joy_port2, joy_port3
    input  wire logic [47:0] s_tdata,
    // opcode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data, sprite_bank, nmi_on, irq_on, rom_bank, sound_strobe,
    // sound_byte, irq_pulse, nmi_pulse, scroll_value
    output logic      [47:0] m_tdata
);

    aidec_item_t item;
    aidec_res_t  res;
    logic        accept;

    logic                 out_valid_reg;
    aidec_res_t           out_res_reg;
    logic                 out_ram_ok_reg;
    logic [RAM_DEPTH-1:0] ram_valid_reg;
    logic [7:0]           ram_rdata;
    logic [7:0]           read_data;
    logic [RAM_AW-1:0]    ram_idx;

    assign item.opcode      = s_tuser;
    assign item.bus_address = s_tdata[15:0];
    assign item.write_data  = s_tdata[23:16];
    assign item.joy_port1   = s_tdata[31:24];
    assign item.joy_port2   = s_tdata[39:32];
    assign item.joy_port3   = s_tdata[47:40];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign ram_idx  = item.bus_address[RAM_AW-1:0];

    aidec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .accept    (accept),
        .res       (res)
    );

    aidec_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && res.ram_we),
        .waddr (ram_idx),
        .wdata (item.write_data),
        .re    (accept && res.ram_re),
        .raddr (ram_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && res.ram_we)
            begin
                ram_valid_reg[ram_idx] <= 1'b1;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_res_reg    <= res;
            out_ram_ok_reg <= ram_valid_reg[ram_idx];
        end
    end

    // ram data is held by the read port until the next ram read transfer
    assign read_data = (out_res_reg.ram_re && out_ram_ok_reg) ? ram_rdata
                                                              : out_res_reg.rd_fixed;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.scroll_value,
                       out_res_reg.nmi_pulse,
                       out_res_reg.irq_pulse,
                       out_res_reg.sound_byte,
                       out_res_reg.sound_strobe,
                       out_res_reg.rom_bank,
                       out_res_reg.irq_on,
                       out_res_reg.nmi_on,
                       out_res_reg.sprite_bank,
                       read_data};

endmodule
`default_nettype wire

// ===== hdl/aidec_checker.sv =====
`default_nettype none
module aidec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    // a result stalled by the sink holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an interrupt pulse comes only from a tick, so nothing read or strobed
    a_pulse_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[30] || m_tdata[31]) |-> m_tdata[7:0] == 8'd0 && !m_tdata[21])
        else $error("interrupt pulse mixed with bus access");

    // sound byte is zero unless strobed
    a_sound_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[21] |-> m_tdata[29:22] == 8'd0)
        else $error("sound byte without strobe");

    // a strobed write returns no read data
    a_strobe_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[21] |-> m_tdata[7:0] == 8'd0)
        else $error("read data on sound write");

    // one result per input transfer: with an empty output a transfer shows next cycle
    a_one_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("missing result after transfer");

endmodule

bind arcade_io_and_interrupt_decoder_top aidec_checker u_aidec_checker (.*);
`default_nettype wire

// ===== tb/tb_arcade_io_and_interrupt_decoder_top.sv =====
`timescale 1ns / 100ps
module tb_arcade_io_and_interrupt_decoder_top;
    import aidec_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         IDLE_PCT     = 22;
    localparam int         HOLD_AT      = 150;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 5000;
    localparam logic [7:0] DIR_DIP0     = 8'h81;
    localparam logic [7:0] DIR_DIP1     = 8'hff;
    localparam logic [7:0] DIR_DIP2     = 8'h00;

    // output tdata layout, highest field first
    typedef struct packed {
        logic [15:0] scroll_value;
        logic        nmi_pulse;
        logic        irq_pulse;
        logic [7:0]  sound_byte;
        logic        sound_strobe;
        logic [2:0]  rom_bank;
        logic        irq_on;
        logic        nmi_on;
        logic [7:0]  sprite_bank;
        logic [7:0]  read_data;
    } bus_result_t;

    typedef struct {
        aidec_item_t it;
        bit          typed;
        bus_result_t want;
    } dir_row_t;

    typedef struct {
        logic [1:0] board;
        bit         rand_dips;
        logic [7:0] dip;
        int         n_items;
        int         tick_pct;
        bit         no_idle;
    } phase_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    arcade_io_and_interrupt_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted block state
    logic [7:0] scroll_mem [RAM_DEPTH];
    logic [7:0] sprite_q;
    logic       nmi_en;
    logic       irq_en;
    logic [2:0] bank_q;
    logic [4:0] slice_q;
    logic [1:0] board_q;
    logic [7:0] dip0_q;
    logic [7:0] dip1_q;
    logic [7:0] dip2_q;

    bus_result_t pending_results[$];
    dir_row_t    dir_rows[$];
    phase_t      phases[6];
    int          err_count;
    int          rcv_count;
    bit          steady;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bus_result_t predict_bus_result(input aidec_item_t it);
        bus_result_t r;
        logic [7:0]  irq_mask;
        logic [4:0]  frame_end;
        r = '0;
        case (it.opcode)
            OP_WRITE:
            begin
                if (it.bus_address[15:6] == ADDR_RAM_BASE[15:6])
                    scroll_mem[it.bus_address[5:0]] = it.write_data;
                else if (it.bus_address == ADDR_SPRITE_BANK)
                    sprite_q = it.write_data;
                else if (it.bus_address == ADDR_INT_ENABLE)
                begin
                    irq_mask = board_q[1] ? IRQ_MASK_ALT : IRQ_MASK_STD;
                    nmi_en = it.write_data[0];
                    irq_en = |(it.write_data & irq_mask);
                end
                else if (it.bus_address == ADDR_ROM_BANK)
                begin
                    if (board_q == BOARD_BANKED)
                        bank_q = it.write_data[7:5];
                end
                else if (it.bus_address == ADDR_SOUND_DIP2)
                begin
                    r.sound_strobe = 1'b1;
                    r.sound_byte = it.write_data;
                end
            end
            OP_READ:
            begin
                case (it.bus_address)
                    ADDR_DIP1:       r.read_data = dip1_q;
                    ADDR_SOUND_DIP2: r.read_data = dip2_q;
                    ADDR_DIP0:       r.read_data = dip0_q;
                    ADDR_JOY2:       r.read_data = ~it.joy_port2;
                    ADDR_JOY1:       r.read_data = ~it.joy_port1;
                    ADDR_JOY3:       r.read_data = ~it.joy_port3;
                    default:
                    begin
                        if (it.bus_address[15:6] == ADDR_RAM_BASE[15:6])
                            r.read_data = scroll_mem[it.bus_address[5:0]];
                    end
                endcase
            end
            OP_TICK:
            begin
                frame_end = (board_q != 2'd0) ? SLICE_LAST_16 : SLICE_LAST_32;
                r.irq_pulse = irq_en && (slice_q == frame_end);
                r.nmi_pulse = nmi_en && slice_q[0];
                // a count left past the frame end by a board change wraps too
                if (slice_q >= frame_end)
                    slice_q = 5'd0;
                else
                    slice_q = slice_q + 5'd1;
            end
            default: ;
        endcase
        r.sprite_bank = sprite_q;
        r.nmi_on = nmi_en;
        r.irq_on = irq_en;
        r.rom_bank = bank_q;
        r.scroll_value = {scroll_mem[SCROLL_HI_IDX], scroll_mem[SCROLL_LO_IDX]};
        return r;
    endfunction

    function automatic aidec_item_t make_item(input logic [1:0] op, input logic [15:0] addr,
                                              input logic [7:0] data, input logic [7:0] j1,
                                              input logic [7:0] j2, input logic [7:0] j3);
        aidec_item_t it;
        it.opcode = op;
        it.bus_address = addr;
        it.write_data = data;
        it.joy_port1 = j1;
        it.joy_port2 = j2;
        it.joy_port3 = j3;
        return it;
    endfunction

    function automatic aidec_item_t random_item(input int tick_pct);
        int          pick;
        int          sel;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [1:0]  op;
        pick = $urandom_range(99);
        sel = $urandom_range(9);
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < tick_pct)
            op = OP_TICK;
        else if (pick < tick_pct + 3)
            op = OP_NONE;
        else if ($urandom_range(99) < 55)
        begin
            op = OP_WRITE;
            case (sel)
                0, 1, 2, 3: addr = ADDR_RAM_BASE | 16'($urandom_range(RAM_DEPTH - 1));
                4: addr = ADDR_SPRITE_BANK;
                5:
                begin
                    addr = ADDR_INT_ENABLE;
                    // mostly keep the interrupts enabled so frames reach their end
                    if ($urandom_range(99) < 75)
                        data = data | 8'h07;
                end
                6: addr = ADDR_ROM_BANK;
                7: addr = ADDR_SOUND_DIP2;
                8: addr = ADDR_DIP0;
                default: ;
            endcase
        end
        else
        begin
            op = OP_READ;
            case (sel)
                0, 1, 2: addr = ADDR_RAM_BASE | 16'($urandom_range(RAM_DEPTH - 1));
                3: addr = ADDR_DIP1;
                4: addr = ADDR_SOUND_DIP2;
                5: addr = ADDR_DIP0;
                6: addr = ADDR_JOY2;
                7: addr = ADDR_JOY1;
                8: addr = ADDR_JOY3;
                default: ;
            endcase
        end
        return make_item(op, addr, data, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                           input logic [7:0] j1, input logic [7:0] j2, input logic [7:0] j3,
                           input bit typed, input logic [7:0] want_rd);
        dir_row_t row;
        row.it = make_item(op, addr, data, j1, j2, j3);
        row.typed = typed;
        row.want = '0;
        row.want.read_data = want_rd;
        dir_rows.push_back(row);
    endtask

    // called at a rising edge; leaves s_tvalid high unless an idle gap is taken
    task automatic send_item(input aidec_item_t it, input bit typed, input bus_result_t want);
        bus_result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser <= it.opcode;
        s_tdata <= {it.joy_port3, it.joy_port2, it.joy_port1, it.write_data, it.bus_address};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_bus_result(it);
        pending_results.push_back(typed ? want : predicted);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic [1:0] board, input logic [7:0] d0,
                                input logic [7:0] d1, input logic [7:0] d2);
        logic [7:0] vals[4];
        logic [1:0] idx[4];
        vals = '{8'(board), d0, d1, d2};
        idx = '{CFG_BOARD_TYPE, CFG_DIP_BANK0, CFG_DIP_BANK1, CFG_DIP_BANK2};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        board_q = board;
        dip0_q = d0;
        dip1_q = d1;
        dip2_q = d2;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // result side
    initial
    begin
        bus_result_t got;
        bus_result_t want;
        m_tready = 1'b0;
        rcv_count = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_results.size() == 0)
                begin
                    $error("result 0x%012h with nothing expected", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_data", 16'(want.read_data), 16'(got.read_data));
                    check_field("sprite_bank", 16'(want.sprite_bank), 16'(got.sprite_bank));
                    check_field("nmi_on", 16'(want.nmi_on), 16'(got.nmi_on));
                    check_field("irq_on", 16'(want.irq_on), 16'(got.irq_on));
                    check_field("rom_bank", 16'(want.rom_bank), 16'(got.rom_bank));
                    check_field("sound_strobe", 16'(want.sound_strobe),
                                16'(got.sound_strobe));
                    check_field("sound_byte", 16'(want.sound_byte), 16'(got.sound_byte));
                    check_field("irq_pulse", 16'(want.irq_pulse), 16'(got.irq_pulse));
                    check_field("nmi_pulse", 16'(want.nmi_pulse), 16'(got.nmi_pulse));
                    check_field("scroll_value", want.scroll_value, got.scroll_value);
                end
                rcv_count++;
                if (rcv_count == HOLD_AT)
                begin
                    // long back-pressure while the sender keeps offering
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    m_tready <= 1'b1;
                end
                else
                    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // stall watchdog
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_arcade_io_and_interrupt_decoder_top NOT OK");
        $finish;
    end

    initial
    begin
        phase_t ph;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        cfg_we = 1'b0;
        cfg_index = CFG_BOARD_TYPE;
        cfg_data = 8'h00;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_WRITE;
        err_count = 0;
        steady = 1'b0;
        for (int i = 0; i < RAM_DEPTH; i++)
            scroll_mem[i] = 8'h00;
        sprite_q = 8'h00;
        nmi_en = 1'b0;
        irq_en = 1'b0;
        bank_q = 3'd0;
        slice_q = 5'd0;
        board_q = 2'd0;
        dip0_q = 8'h00;
        dip1_q = 8'h00;
        dip2_q = 8'h00;

        // fresh state: reads give zero, dips or inverted inputs; then idle, tick and write rows
        add_row(OP_READ,  ADDR_RAM_BASE,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        add_row(OP_READ,  16'hE03F,         8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
        add_row(OP_READ,  ADDR_JOY2,        8'h00, 8'h5a, 8'h00, 8'h5a, 1'b1, 8'hff);
        add_row(OP_READ,  ADDR_JOY1,        8'h00, 8'hff, 8'h00, 8'h00, 1'b1, 8'h00);
        add_row(OP_READ,  ADDR_JOY3,        8'h00, 8'h00, 8'h00, 8'ha5, 1'b1, 8'h5a);
        add_row(OP_READ,  ADDR_DIP0,        8'h00, 8'h00, 8'h00, 8'h00, 1'b1, DIR_DIP0);
        add_row(OP_READ,  ADDR_DIP1,        8'h00, 8'h00, 8'h00, 8'h00, 1'b1, DIR_DIP1);
        add_row(OP_READ,  ADDR_SOUND_DIP2,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, DIR_DIP2);
        add_row(OP_READ,  16'hFFFF,         8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
        add_row(OP_NONE,  ADDR_INT_ENABLE,  8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        add_row(OP_TICK,  16'h0000,         8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
        add_row(OP_WRITE, 16'hE006,         8'h34, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, 16'hE026,         8'h12, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, 16'hE03F,         8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, 16'hE040,         8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, 16'hDFFF,         8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, ADDR_SPRITE_BANK, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, ADDR_INT_ENABLE,  8'h05, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, ADDR_ROM_BANK,    8'he0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, ADDR_SOUND_DIP2,  8'ha5, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, ADDR_DIP0,        8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_READ,  16'hE03F,         8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_TICK,  16'hFFFF,         8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_TICK,  16'h0000,         8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);
        add_row(OP_WRITE, ADDR_INT_ENABLE,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00);

        // tick-heavy on 32 slices first so the next 16-slice board starts past its end
        phases[0] = '{2'd0, 1'b0, 8'h00, 80, 60, 1'b0};
        phases[1] = '{2'd1, 1'b0, 8'hff, 80, 30, 1'b0};
        phases[2] = '{2'd2, 1'b1, 8'h00, 100, 25, 1'b0};
        phases[3] = '{2'd3, 1'b1, 8'h00, 100, 30, 1'b1};
        phases[4] = '{2'd2, 1'b1, 8'h00, 80, 35, 1'b0};
        phases[5] = '{2'd0, 1'b1, 8'h00, 70, 45, 1'b0};

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_config(2'd0, DIR_DIP0, DIR_DIP1, DIR_DIP2);
        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        foreach (phases[p])
        begin
            ph = phases[p];
            d0 = ph.rand_dips ? 8'($urandom) : ph.dip;
            d1 = ph.rand_dips ? 8'($urandom) : ph.dip;
            d2 = ph.rand_dips ? 8'($urandom) : ph.dip;
            apply_config(ph.board, d0, d1, d2);
            steady = ph.no_idle;
            repeat (ph.n_items)
                send_item(random_item(ph.tick_pct), 1'b0, '0);
            drain_results();
            steady = 1'b0;
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("tb_arcade_io_and_interrupt_decoder_top OK");
        else
            $display("tb_arcade_io_and_interrupt_decoder_top NOT OK");
        $finish;
    end

endmodule
